// ===== hdl/plc_pkg.sv =====
`timescale 1ns / 1ps
package plc_pkg;

  localparam int SAMPLE_BITS = 24;

  typedef struct packed {
    logic                   func;
    logic [3:0]             node_index;
    logic [23:0]            node_count_value;
    logic [31:0]            node_value;
    logic [SAMPLE_BITS-1:0] sample;
  } plc_in_t;

  typedef struct packed {
    logic [47:0] result;
    logic        saturated;
  } plc_out_t;

  localparam logic [0:0] CFG_NODE_COUNT = 1'd0;
  localparam logic [0:0] CFG_DECIMAL_DIGITS = 1'd1;

  localparam int PROD_W = 100;
  localparam int SPAN_W = 33;

  function automatic logic [19:0] pow10(input logic [2:0] d);
    case (d)
      3'd0: pow10 = 20'd1;
      3'd1: pow10 = 20'd10;
      3'd2: pow10 = 20'd100;
      3'd3: pow10 = 20'd1000;
      3'd4: pow10 = 20'd10000;
      3'd5: pow10 = 20'd100000;
      default: pow10 = 20'd1000000;
    endcase
  endfunction

endpackage

// ===== hdl/plc_ram.sv =====
`timescale 1ns / 1ps
module plc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/plc_serdiv.sv =====
`timescale 1ns / 1ps
// bit-serial restoring divider, one quotient bit per cycle
module plc_serdiv
  import plc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [SPAN_W-1:0] divisor,
  output logic              done,
  output logic [PROD_W-1:0] quotient
);
  localparam int CW = $clog2(PROD_W + 1);

  logic [PROD_W-1:0] q_r, q_nxt;
  logic [SPAN_W:0]   rem_r, rem_nxt;
  logic [SPAN_W-1:0] dv_r, dv_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic [SPAN_W:0]   trial;
  logic [SPAN_W+1:0] diff;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    dv_nxt = dv_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    trial = {rem_r[SPAN_W-1:0], q_r[PROD_W-1]};
    diff = {1'b0, trial} - {2'b00, dv_r};
    if (start) begin
      q_nxt = dividend;
      rem_nxt = '0;
      dv_nxt = divisor;
      cnt_nxt = CW'(PROD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[SPAN_W+1]) begin
        rem_nxt = diff[SPAN_W:0];
      end else begin
        rem_nxt = trial;
      end
      q_nxt = {q_r[PROD_W-2:0], !diff[SPAN_W+1]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    dv_r <= dv_nxt;
  end

  assign done = busy_r && (cnt_r == CW'(1));
  assign quotient = q_nxt;
endmodule

// ===== hdl/piecewise_linear_calibrator_top.sv =====
`timescale 1ns / 1ps
// node write: next item the following cycle; one item at a time
// conversion: node scan (ST_SCAN, ST_RD1W per node), the bit-serial multiplies, the bit-serial divider,
// then add and saturate; result held until out_ready; next transfer the cycle after the result is taken
// fewer than two nodes: result valid the cycle after the transfer
// synchronous active-low reset clears control state and config; node table undefined
module piecewise_linear_calibrator_top
  import plc_pkg::*;
#(
  parameter int NODES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  plc_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output plc_out_t    out_data,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [4:0]  cfg_data
);
  localparam int AW = $clog2(NODES);
  localparam int NW = $clog2(NODES + 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SCAN = 4'd1;
  localparam logic [3:0] ST_RD1 = 4'd2;
  localparam logic [3:0] ST_RD1W = 4'd3;
  localparam logic [3:0] ST_RD2 = 4'd4;
  localparam logic [3:0] ST_PREP = 4'd5;
  localparam logic [3:0] ST_MUL1 = 4'd6;
  localparam logic [3:0] ST_MUL2 = 4'd7;
  localparam logic [3:0] ST_DIV = 4'd8;
  localparam logic [3:0] ST_ADD = 4'd9;
  localparam logic [3:0] ST_FIN = 4'd10;
  localparam logic [3:0] ST_OUT = 4'd11;
  localparam logic [3:0] ST_ZCHK = 4'd12;

  logic [4:0] node_count_r;
  logic [2:0] dec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= '0;
      dec_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_NODE_COUNT) begin
        node_count_r <= cfg_data;
      end else begin
        dec_r <= cfg_data[2:0];
      end
    end
  end

  logic [3:0]  st_r, st_nxt;
  logic [NW:0] n_eff;
  logic [23:0] s_r;
  logic [NW:0] i_r, i_nxt;
  logic [NW:0] idx_r, idx_nxt;
  logic        pend_r;
  logic [AW-1:0] raddr;
  logic [23:0] rc;
  logic [31:0] rv;
  logic        wr_en;

  assign n_eff = (NW+1)'(node_count_r) > (NW+1)'(NODES) ? (NW+1)'(NODES)
               : (NW+1)'(node_count_r);
  assign wr_en = in_valid && in_ready && !in_data.func
               && (32'(in_data.node_index) < 32'(NODES));

  plc_ram #(.WIDTH(24), .DEPTH(NODES)) u_cnt (
    .clk(clk), .we(wr_en), .waddr(AW'(in_data.node_index)),
    .wdata(in_data.node_count_value), .raddr(raddr), .rdata(rc));
  plc_ram #(.WIDTH(32), .DEPTH(NODES)) u_val (
    .clk(clk), .we(wr_en), .waddr(AW'(in_data.node_index)),
    .wdata(in_data.node_value), .raddr(raddr), .rdata(rv));

  logic [23:0] c1_r;
  logic signed [31:0] v1_r;
  logic signed [24:0] span_r;

  // serial multiply state
  logic [PROD_W-1:0] acc_r, acc_nxt;
  logic [PROD_W-1:0] mcand_r, mcand_nxt;
  logic [31:0] mplier_r, mplier_nxt;
  logic [5:0]  mcnt_r, mcnt_nxt;
  logic        neg_r;
  logic signed [52:0] base_r;
  logic [PROD_W-1:0] quo;
  logic        div_start, div_done;
  logic [59:0] q_r;
  logic signed [61:0] sum_r;
  plc_out_t    res_r, res_nxt;
  logic        ovf_r;

  plc_serdiv u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(acc_r),
    .divisor(span_r[24] ? SPAN_W'(-33'(span_r)) : SPAN_W'(span_r)),
    .done(div_done), .quotient(quo));

  assign in_ready = (st_r == ST_IDLE);
  assign out_valid = (st_r == ST_OUT);
  assign out_data = res_r;
  assign raddr = AW'(i_r);
  assign div_start = (st_r == ST_MUL2) && (mcnt_r == 6'd0);

  logic [19:0] scl;
  assign scl = pow10(dec_r > 3'd6 ? 3'd6 : dec_r);

  logic signed [24:0] off_c;
  logic signed [32:0] dv_c;
  logic signed [24:0] sp_c;
  logic signed [61:0] sum_c;
  assign off_c = $signed({1'b0, s_r}) - $signed({1'b0, c1_r});
  assign dv_c = 33'($signed(rv)) - 33'(v1_r);
  assign sp_c = $signed({1'b0, rc}) - $signed({1'b0, c1_r});
  assign sum_c = (neg_r ? -62'($signed({1'b0, q_r}))
                        : 62'($signed({1'b0, q_r}))) + 62'(base_r);

  always_comb begin
    st_nxt = st_r;
    i_nxt = i_r;
    idx_nxt = idx_r;
    acc_nxt = acc_r;
    mcand_nxt = mcand_r;
    mplier_nxt = mplier_r;
    mcnt_nxt = mcnt_r;
    res_nxt = res_r;
    case (st_r)
      ST_IDLE: begin
        if (in_valid && in_data.func) begin
          if (n_eff < (NW+1)'(2)) begin
            res_nxt.result = 48'({in_data.sample, 8'd0});
            res_nxt.saturated = 1'b0;
            st_nxt = ST_OUT;
          end else begin
            i_nxt = '0;
            idx_nxt = n_eff;
            st_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // read issued for i_r; compare next cycle
        st_nxt = ST_RD1W;
      end
      ST_RD1W: begin
        if (s_r < rc) begin
          idx_nxt = i_r - 1'b1;
          if (i_r == '0) begin
            // below the first node: first segment
            idx_nxt = '0;
            st_nxt = ST_RD1;
            i_nxt = '0;
          end else begin
            i_nxt = i_r - 1'b1;
            st_nxt = ST_ZCHK;
          end
        end else if (i_r + 1'b1 == n_eff) begin
          i_nxt = n_eff - (NW+1)'(2);
          idx_nxt = n_eff - (NW+1)'(2);
          st_nxt = ST_RD1;
        end else begin
          i_nxt = i_r + 1'b1;
          st_nxt = ST_SCAN;
        end
      end
      ST_ZCHK: begin
        // idx is valid segment start here; data of idx arrives next cycle
        st_nxt = ST_RD1;
        if (idx_r > n_eff - (NW+1)'(2)) begin
          idx_nxt = n_eff - (NW+1)'(2);
          i_nxt = n_eff - (NW+1)'(2);
        end
      end
      ST_RD1: begin
        i_nxt = idx_r + 1'b1;
        st_nxt = ST_RD2;
      end
      ST_RD2: begin
        st_nxt = ST_PREP;
      end
      ST_PREP: begin
        if (pend_r) begin
          // the last segment stays put since the clamp would bring it back
          if (idx_r != n_eff - (NW+1)'(2) && (rv[31] || rv == 32'd0)) begin
            idx_nxt = idx_r + 1'b1;
            i_nxt = idx_r + 1'b1;
          end else begin
            i_nxt = idx_r;
          end
          st_nxt = ST_RD1;
        end else begin
          acc_nxt = '0;
          mcand_nxt = PROD_W'(dv_c[32] ? -dv_c : dv_c);
          mplier_nxt = 32'(off_c[24] ? -off_c : off_c);
          mcnt_nxt = 6'd25;
          st_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        if (mplier_r[0]) begin
          acc_nxt = acc_r + mcand_r;
        end
        mcand_nxt = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        mcnt_nxt = mcnt_r - 1'b1;
        if (mcnt_r == 6'd1) begin
          mcand_nxt = acc_nxt;
          acc_nxt = '0;
          mplier_nxt = 32'(scl);
          mcnt_nxt = 6'd20;
          st_nxt = ST_MUL2;
        end
      end
      ST_MUL2: begin
        if (mcnt_r != 6'd0) begin
          if (mplier_r[0]) begin
            acc_nxt = acc_r + mcand_r;
          end
          mcand_nxt = mcand_r << 1;
          mplier_nxt = mplier_r >> 1;
          mcnt_nxt = mcnt_r - 1'b1;
        end else begin
          st_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          st_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        st_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (ovf_r) begin
          res_nxt.result = neg_r ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
          res_nxt.saturated = 1'b1;
        end else if (sum_r > 62'sh7FFFFFFFFFFF) begin
          res_nxt.result = {1'b0, {47{1'b1}}};
          res_nxt.saturated = 1'b1;
        end else if (sum_r < -62'sh800000000000) begin
          res_nxt.result = {1'b1, 47'd0};
          res_nxt.saturated = 1'b1;
        end else begin
          res_nxt.result = sum_r[47:0];
          res_nxt.saturated = 1'b0;
        end
        st_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      pend_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_ZCHK) begin
        pend_r <= 1'b1;
      end else if (st_r == ST_PREP || st_r == ST_IDLE) begin
        pend_r <= 1'b0;
      end else if (st_r == ST_RD2 && pend_r && !(rc == 24'd0 && rv == 32'd0)) begin
        // zero-node check only where the start node is (0,0)
        pend_r <= 1'b0;
      end
    end
    i_r <= i_nxt;
    idx_r <= idx_nxt;
    acc_r <= acc_nxt;
    mcand_r <= mcand_nxt;
    mplier_r <= mplier_nxt;
    mcnt_r <= mcnt_nxt;
    res_r <= res_nxt;
    if (st_r == ST_IDLE) begin
      s_r <= in_data.sample;
    end
    if (st_r == ST_RD2) begin
      c1_r <= rc;
      v1_r <= rv;
    end
    if (st_r == ST_PREP && !pend_r) begin
      span_r <= (sp_c == 25'sd0) ? 25'sd1 : sp_c;
      neg_r <= ((off_c < 0) != (dv_c < 0)) != ((sp_c < 0) && (sp_c != 0));
    end
    if (st_r == ST_MUL1 && mcnt_r == 6'd25) begin
      base_r <= 53'(v1_r) * $signed({1'b0, scl});
    end
    if (st_r == ST_DIV && div_done) begin
      q_r <= quo[59:0];
      ovf_r <= |quo[PROD_W-1:60];
    end
    if (st_r == ST_ADD) begin
      sum_r <= sum_c;
    end
  end
endmodule
